[rtl/core/fat_cluster_chain_lookup_assert.svh]
// assertion macros shared by the fat cluster chain lookup rtl
// expects aclk and active-low aresetn in the including module
`ifndef FAT_CLUSTER_CHAIN_LOOKUP_ASSERT_SVH
`define FAT_CLUSTER_CHAIN_LOOKUP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FATCL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define FATCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fatcl_pkg.sv]
// shared constants, codes and types for the fat cluster chain lookup
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fatcl_pkg;

    // cached window geometry (sector size is a power of two)
    localparam int WINDOW_SECTORS = 4;
    localparam int SECTOR_BYTES   = 512;
    localparam int WIN_BYTES      = WINDOW_SECTORS * SECTOR_BYTES;
    localparam int WIN_AW         = $clog2(WIN_BYTES);
    localparam int BANK_DEPTH     = WIN_BYTES / 4;
    localparam int BANK_AW        = WIN_AW - 2;
    localparam int SECT_SHIFT     = $clog2(SECTOR_BYTES);

    // field widths
    localparam int CLUSTER_W  = 28;
    localparam int FOFF_W     = 11;
    localparam int BYTE_W     = 8;
    localparam int OFF_W      = 30;
    localparam int SEC_W      = OFF_W - SECT_SHIFT;
    localparam int WFIRST_W   = 22;
    localparam int LBA_W      = 32;
    localparam int FSS_W      = 16;
    localparam int SPC_W      = 8;
    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 96;
    localparam int M_TUSER_W  = 2;
    localparam int M_PAD_W    = M_TDATA_W - (CLUSTER_W + 1 + LBA_W + LBA_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAT_KIND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAT_START  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPC        = 2'd3;

    // fat variants, code 3 decodes as fat32
    localparam logic [1:0] FAT_12 = 2'd0;
    localparam logic [1:0] FAT_16 = 2'd1;
    localparam logic [1:0] FAT_32 = 2'd2;

    // input word kinds
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_FILL   = 1'b1;

    // entry decoding constants
    localparam logic [11:0]          FAT12_EOC  = 12'hFF8;
    localparam logic [15:0]          FAT16_EOC  = 16'hFFF8;
    localparam logic [CLUSTER_W-1:0] FAT32_EOC  = 28'hFFFFFF8;
    localparam logic [LBA_W-1:0]     FIRST_DATA_CLUSTER = 32'd2;

    typedef enum logic [1:0] {
        ST_HIT  = 2'd0,
        ST_MISS = 2'd1,
        ST_FILL = 2'd2
    } status_t;

endpackage

`default_nettype wire

[rtl/core/fat_cluster_chain_lookup.sv]
// Next-cluster lookup for FAT12/16/32 from a 4-sector cached FAT window. One input
// word is accepted every cycle unless the output stalls, and each gives exactly one
// result word after the input register, window check with state update and window
// read, entry decode, then the next-LBA multiply-add into the output register. The
// window is four byte-lane banks, so any entry, including a FAT12 entry that crosses a
// 32-bit boundary, reads in a single pass. A lookup miss returns the sector to load
// and moves the window there; fill words then write window bytes and the lookup is
// repeated. Window bytes are undefined until filled and need no clearing pass.
// depends on fatcl_pkg, fatcl_window, fat_cluster_chain_lookup_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "fat_cluster_chain_lookup_assert.svh"

module fat_cluster_chain_lookup (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fatcl_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [fatcl_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cluster, fill_offset, fill_byte, zero pad
    input  logic [fatcl_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind
    input  logic [fatcl_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // chain link, end_of_chain, next_lba, load_sector, zero pad
    output logic [fatcl_pkg::M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [fatcl_pkg::M_TUSER_W-1:0]  m_tuser
);
    import fatcl_pkg::*;

    // configuration
    logic [1:0]       fat_kind_reg;
    logic [FSS_W-1:0] fat_start_reg;
    logic [LBA_W-1:0] data_start_reg;
    logic [SPC_W-1:0] spc_reg;

    // window state
    logic [WFIRST_W-1:0] wfirst_reg, wfirst_next;
    logic                window_valid_reg, window_valid_next;

    // stage 1: input register
    logic                 v1_reg;
    logic                 kind1_reg;
    logic [CLUSTER_W-1:0] cl1_reg;
    logic [FOFF_W-1:0]    foff1_reg;
    logic [BYTE_W-1:0]    fbyte1_reg;

    // stage 2: window check done, read in flight
    logic             v2_reg;
    logic             fill2_reg;
    logic             hit2_reg;
    logic             odd2_reg;
    logic [LBA_W-1:0] load2_reg;

    // stage 3: decoded entry
    logic                 v3_reg;
    status_t              status3_reg, status3_next;
    logic [CLUSTER_W-1:0] next3_reg, next3_next;
    logic                 eoc3_reg, eoc3_next;
    logic [LBA_W-1:0]     load3_reg, load3_next;

    // stage 4: output register
    logic                 v4_reg;
    status_t              status4_reg;
    logic [CLUSTER_W-1:0] next4_reg;
    logic                 eoc4_reg;
    logic [LBA_W-1:0]     lba4_reg, lba4_next;
    logic [LBA_W-1:0]     load4_reg;

    logic rdy1, rdy2, rdy3, rdy4;
    logic do2;

    logic [OFF_W-1:0]    off;
    logic [SEC_W-1:0]    sec;
    logic [WFIRST_W-1:0] sec_ext;
    logic [WFIRST_W-1:0] diff;
    logic [WIN_AW-1:0]   rel;
    logic                in_range, straddle, hit;
    logic [LBA_W-1:0]    load_sector;
    logic                win_wr_en;
    logic [31:0]         rd_word;
    logic [LBA_W-1:0]    nm2, prod;

    // per-stage flow control
    assign rdy4 = !v4_reg || m_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign do2 = v1_reg && rdy2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fat_kind_reg   <= FAT_12;
            fat_start_reg  <= '0;
            data_start_reg <= '0;
            spc_reg        <= SPC_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_FAT_KIND:   fat_kind_reg   <= cfg_wr_data[1:0];
                CFG_FAT_START:  fat_start_reg  <= cfg_wr_data[FSS_W-1:0];
                CFG_DATA_START: data_start_reg <= cfg_wr_data[LBA_W-1:0];
                CFG_SPC:        spc_reg        <= cfg_wr_data[SPC_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            kind1_reg  <= s_tuser[0];
            cl1_reg    <= s_tdata[CLUSTER_W-1:0];
            foff1_reg  <= s_tdata[CLUSTER_W +: FOFF_W];
            fbyte1_reg <= s_tdata[CLUSTER_W+FOFF_W +: BYTE_W];
        end
    end

    // entry byte offset and window check
    always_comb begin
        case (fat_kind_reg)
            FAT_12:  off = (OFF_W'({cl1_reg, 1'b0}) + OFF_W'(cl1_reg)) >> 1;
            FAT_16:  off = OFF_W'({cl1_reg, 1'b0});
            default: off = OFF_W'({cl1_reg, 2'b00});
        endcase
        sec      = off[OFF_W-1:SECT_SHIFT];
        sec_ext  = WFIRST_W'(sec);
        diff     = sec_ext - wfirst_reg;
        in_range = window_valid_reg && (sec_ext >= wfirst_reg)
                   && (diff < WFIRST_W'(WINDOW_SECTORS));
        rel      = WIN_AW'({diff, off[SECT_SHIFT-1:0]});
        straddle = (fat_kind_reg == FAT_12) && (rel == WIN_AW'(WIN_BYTES - 1));
        hit      = in_range && !straddle;
        load_sector = LBA_W'(fat_start_reg) + LBA_W'(sec);
    end

    always_comb begin
        wfirst_next       = wfirst_reg;
        window_valid_next = window_valid_reg;
        if (do2 && kind1_reg == KIND_LOOKUP && !hit) begin
            wfirst_next       = sec_ext;
            window_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wfirst_reg       <= '0;
            window_valid_reg <= 1'b0;
        end else begin
            wfirst_reg       <= wfirst_next;
            window_valid_reg <= window_valid_next;
        end
    end

    assign win_wr_en = do2 && (kind1_reg == KIND_FILL) && (int'(foff1_reg) < WIN_BYTES);

    fatcl_window u_window (
        .aclk    (aclk),
        .wr_en   (win_wr_en),
        .wr_addr (WIN_AW'(foff1_reg)),
        .wr_data (fbyte1_reg),
        .rd_en   (do2),
        .rd_addr (rel),
        .rd_word (rd_word)
    );

    // stage 2
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (do2) begin
            fill2_reg <= (kind1_reg == KIND_FILL);
            hit2_reg  <= hit;
            odd2_reg  <= cl1_reg[0];
            load2_reg <= load_sector;
        end
    end

    // entry decode
    always_comb begin
        logic [11:0] ent12;
        ent12        = odd2_reg ? rd_word[15:4] : rd_word[11:0];
        status3_next = ST_HIT;
        next3_next   = '0;
        eoc3_next    = 1'b0;
        load3_next   = '0;
        if (fill2_reg) begin
            status3_next = ST_FILL;
        end else if (!hit2_reg) begin
            status3_next = ST_MISS;
            load3_next   = load2_reg;
        end else begin
            case (fat_kind_reg)
                FAT_12: begin
                    next3_next = CLUSTER_W'(ent12);
                    eoc3_next  = ent12 >= FAT12_EOC;
                end
                FAT_16: begin
                    next3_next = CLUSTER_W'(rd_word[15:0]);
                    eoc3_next  = rd_word[15:0] >= FAT16_EOC;
                end
                default: begin
                    next3_next = rd_word[CLUSTER_W-1:0];
                    eoc3_next  = rd_word[CLUSTER_W-1:0] >= FAT32_EOC;
                end
            endcase
        end
    end

    // stage 3
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            status3_reg <= status3_next;
            next3_reg   <= next3_next;
            eoc3_reg    <= eoc3_next;
            load3_reg   <= load3_next;
        end
    end

    // first lba of the next cluster, modulo 2^32
    always_comb begin
        nm2  = LBA_W'(next3_reg) - FIRST_DATA_CLUSTER;
        prod = nm2 * LBA_W'(spc_reg);
        lba4_next = (status3_reg == ST_HIT) ? data_start_reg + prod : '0;
    end

    // stage 4
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (rdy4) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            status4_reg <= status3_reg;
            next4_reg   <= next3_reg;
            eoc4_reg    <= eoc3_reg;
            lba4_reg    <= lba4_next;
            load4_reg   <= load3_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tuser  = status4_reg;
    assign m_tdata  = {M_PAD_W'(0), load4_reg, lba4_reg, eoc4_reg, next4_reg};

    `FATCL_ASSERT_NEXT(a_miss_moves_window, do2 && kind1_reg == KIND_LOOKUP && !hit, window_valid_reg && wfirst_reg == $past(sec_ext), "miss did not move the window")
    `FATCL_ASSERT_IMPL(a_hit_needs_window, m_tvalid && m_tuser == ST_HIT, window_valid_reg, "hit reported with empty window")
    `FATCL_ASSERT_IMPL(a_fill_word_clean, m_tvalid && m_tuser == ST_FILL, m_tdata == '0, "fill word carries payload")
    `FATCL_ASSERT_IMPL(a_miss_word_clean, m_tvalid && m_tuser == ST_MISS, m_tdata[CLUSTER_W+LBA_W:0] == '0, "miss word carries entry data")
    `FATCL_ASSERT_IMPL(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")

endmodule

`default_nettype wire

[rtl/core/fatcl_window.sv]
// cached fat window: four byte-lane banks, one write and one 4-byte read a cycle
// depends on fatcl_pkg
`timescale 1ns / 1ps
`default_nettype none

module fatcl_window (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [fatcl_pkg::WIN_AW-1:0] wr_addr,
    input  logic [fatcl_pkg::BYTE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [fatcl_pkg::WIN_AW-1:0] rd_addr,
    output logic [31:0]                 rd_word   // bytes rd_addr .. rd_addr+3, lowest first
);
    import fatcl_pkg::*;

    logic [BYTE_W-1:0]  rd_q_reg [4];
    logic [1:0]         lane_reg;
    logic [BANK_AW-1:0] bank_idx [4];

    always_comb begin
        logic [1:0]        k;
        logic [WIN_AW-1:0] byte_addr;
        for (int b = 0; b < 4; b++) begin
            k = 2'(b) - rd_addr[1:0];
            byte_addr = rd_addr + WIN_AW'(k);
            bank_idx[b] = byte_addr[WIN_AW-1:2];
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [BYTE_W-1:0] mem [BANK_DEPTH];

        always_ff @(posedge aclk) begin
            if (wr_en && wr_addr[1:0] == 2'(b)) begin
                mem[wr_addr[WIN_AW-1:2]] <= wr_data;
            end
            if (rd_en) begin
                rd_q_reg[b] <= mem[bank_idx[b]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            lane_reg <= rd_addr[1:0];
        end
    end

    // rotate lanes so byte 0 is the one at rd_addr
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rd_word[8*k +: 8] = rd_q_reg[2'(lane_reg + 2'(k))];
        end
    end

endmodule

`default_nettype wire
